[rtl/core/rrpb_pkg.sv]
// rrpb_pkg: shared types and constants of the round-robin pending bitmap
// request and response payloads, opcodes, register indexes, controller links
// no dependencies
`default_nettype none

package rrpb_pkg;

   localparam int FLAG_DEPTH  = 256;
   localparam int IDX_W       = $clog2(FLAG_DEPTH);
   localparam int CNT_W       = $clog2(FLAG_DEPTH + 1);
   localparam int CHUNK       = 8;
   localparam int CHUNK_SEL_W = $clog2(CHUNK);
   localparam int NCHUNK      = FLAG_DEPTH / CHUNK;
   localparam int CHUNK_W     = $clog2(NCHUNK);
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 9;

   localparam logic [2:0] OP_TEST      = 3'd0;
   localparam logic [2:0] OP_SET       = 3'd1;
   localparam logic [2:0] OP_CLEAR     = 3'd2;
   localparam logic [2:0] OP_SET_ALL   = 3'd3;
   localparam logic [2:0] OP_CLEAR_ALL = 3'd4;
   localparam logic [2:0] OP_TAKE      = 3'd5;
   localparam logic [2:0] OP_PEEK      = 3'd6;

   localparam logic [CSR_ADDR_W-1:0] CSR_LIST_SIZE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_READ_ONLY = 1'b1;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] bit_index;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] result_index;
      logic       flag_value;
      logic [8:0] active_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic op_long;
      logic last_chunk;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

[rtl/core/rrpb_ctrl.sv]
// rrpb_ctrl: sequencing state machine of the pending bitmap
// drives datapath commands from request handshake and datapath status
// depends on rrpb_pkg
`default_nettype none

module rrpb_ctrl import rrpb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RUN    = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.op_long ? S_RUN : S_FINISH;
            end
         end
         S_RUN: begin
            cmd.step = 1'b1;
            if (stat.last_chunk) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rrpb_datapath.sv]
// rrpb_datapath: flag store, scan pointer, set count, config and response register
// chunked scan and count units stepped by the controller
// depends on rrpb_pkg
`default_nettype none

module rrpb_datapath import rrpb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire cmd_type               cmd,
   output stat_type                   stat
);

   logic [FLAG_DEPTH-1:0] flags_ff, flags_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [8:0]          list_size_ff;
   logic                read_only_ff;
   req_type             op_ff;
   logic [CHUNK_W-1:0]  chunk_ff;
   logic                found_a_ff, found_b_ff;
   logic [IDX_W-1:0]    idx_a_ff, idx_b_ff;
   logic [CNT_W-1:0]    acc_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;

   logic [CNT_W-1:0]       size;
   logic [CNT_W-1:0]       start;
   logic [CHUNK-1:0]       chunk_bits, mask_a, mask_b, above;
   logic [CHUNK_SEL_W-1:0] lo_a, lo_b;
   logic [CNT_W-1:0]       above_cnt;
   logic                   idx_ok;
   logic                   scan_found;
   logic [IDX_W-1:0]       scan_idx;
   logic [CNT_W-1:0]       next_ptr;

   // effective size, zero taken as one, saturated at the store depth
   always_comb begin
      if (list_size_ff == '0) begin
         size = CNT_W'(1);
      end else if (list_size_ff > CNT_W'(FLAG_DEPTH)) begin
         size = CNT_W'(FLAG_DEPTH);
      end else begin
         size = list_size_ff;
      end
      start = ({1'b0, ptr_ff} < size) ? {1'b0, ptr_ff} : '0;
   end

   // one chunk of the scan and count per step
   always_comb begin
      logic [CNT_W-1:0] bit_idx;
      chunk_bits = flags_ff[{chunk_ff, {CHUNK_SEL_W{1'b0}}} +: CHUNK];
      mask_a     = '0;
      mask_b     = '0;
      above      = '0;
      above_cnt  = '0;
      lo_a       = '0;
      lo_b       = '0;
      for (int j = 0; j < CHUNK; j++) begin
         bit_idx   = {1'b0, chunk_ff, CHUNK_SEL_W'(j)};
         mask_b[j] = chunk_bits[j] && (bit_idx < size);
         mask_a[j] = mask_b[j] && (bit_idx >= start);
         above[j]  = chunk_bits[j] && (bit_idx >= size);
         above_cnt = above_cnt + CNT_W'(above[j]);
      end
      for (int j = CHUNK - 1; j >= 0; j--) begin
         if (mask_a[j]) lo_a = CHUNK_SEL_W'(j);
         if (mask_b[j]) lo_b = CHUNK_SEL_W'(j);
      end
   end

   assign scan_found = found_a_ff || found_b_ff;
   assign scan_idx   = found_a_ff ? idx_a_ff : (found_b_ff ? idx_b_ff : '0);
   assign idx_ok     = {1'b0, op_ff.bit_index} < size;
   assign next_ptr   = {1'b0, scan_idx} + CNT_W'(1);

   // effect of the held request at commit
   always_comb begin
      flags_in = flags_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      rsp_in   = '0;
      case (op_ff.opcode)
         OP_TEST: begin
            rsp_in.flag_value = idx_ok && flags_ff[op_ff.bit_index];
         end
         OP_SET: begin
            if (!read_only_ff && idx_ok && !flags_ff[op_ff.bit_index]) begin
               flags_in[op_ff.bit_index] = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            if (!read_only_ff && idx_ok && flags_ff[op_ff.bit_index]) begin
               flags_in[op_ff.bit_index] = 1'b0;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_SET_ALL: begin
            ptr_in = '0;
            if (!read_only_ff) begin
               for (int i = 0; i < FLAG_DEPTH; i++) begin
                  if (CNT_W'(i) < size) flags_in[i] = 1'b1;
               end
               count_in = size + acc_ff;
            end
         end
         OP_CLEAR_ALL: begin
            ptr_in = '0;
            if (!read_only_ff) begin
               flags_in = '0;
               count_in = '0;
            end
         end
         OP_TAKE: begin
            rsp_in.found        = scan_found;
            rsp_in.result_index = scan_idx;
            if (scan_found) begin
               if (!read_only_ff) begin
                  flags_in[scan_idx] = 1'b0;
                  count_in = count_ff - CNT_W'(1);
               end
               ptr_in = (next_ptr >= size) ? '0 : next_ptr[IDX_W-1:0];
            end
         end
         OP_PEEK: begin
            rsp_in.found        = scan_found;
            rsp_in.result_index = scan_idx;
         end
         default: begin
         end
      endcase
      rsp_in.active_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         list_size_ff <= 9'(FLAG_DEPTH);
         read_only_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_LIST_SIZE: list_size_ff <= csr_wdata;
               CSR_READ_ONLY: read_only_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            flags_ff     <= flags_in;
            count_ff     <= count_in;
            ptr_ff       <= ptr_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_data;
         chunk_ff   <= '0;
         found_a_ff <= 1'b0;
         found_b_ff <= 1'b0;
         idx_a_ff   <= '0;
         idx_b_ff   <= '0;
         acc_ff     <= '0;
      end else if (cmd.step) begin
         chunk_ff <= chunk_ff + CHUNK_W'(1);
         acc_ff   <= acc_ff + above_cnt;
         if (!found_a_ff && (mask_a != '0)) begin
            found_a_ff <= 1'b1;
            idx_a_ff   <= {chunk_ff, lo_a};
         end
         if (!found_b_ff && (mask_b != '0)) begin
            found_b_ff <= 1'b1;
            idx_b_ff   <= {chunk_ff, lo_b};
         end
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.op_long    = (req_data.opcode inside {OP_SET_ALL, OP_TAKE, OP_PEEK});
   assign stat.last_chunk = (chunk_ff == CHUNK_W'(NCHUNK - 1));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FLAG_DEPTH))
      else $error("set count above store depth");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise the response");

   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit overwrote an untaken response");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.result_index == '0))
      else $error("index reported without a hit");

endmodule

`default_nettype wire

[rtl/core/round_robin_pending_bitmap.sv]
// round_robin_pending_bitmap: top level of the round-robin pending flag store
// joins the sequencing controller and the datapath
// depends on rrpb_pkg, rrpb_ctrl, rrpb_datapath
//
// usage
//   req_valid/req_ready/req_data carry one request (opcode, bit_index)
//   rsp_valid/rsp_ready/rsp_data return one response per request, in order
//   csr_we/csr_addr/csr_wdata write list_size (index 0) or read_only (index 1)
//   at once, no wait state; write only while no request is outstanding
// timing
//   one request at a time; the request is held, then committed
//   test, set, clear, clear all: go from acceptance straight to the finish
//   state, which commits once the response slot is free
//   set all, take, peek: first run the 32 steps of the chunk scan/count unit
//   that walks the 256 flags 8 at a time, then finish and commit alike;
//   the next request is taken the cycle after the commit
// reset
//   synchronous, active high: flags, count and pointer cleared,
//   list_size back to 256, read_only off, no response pending
// stalls
//   the response register holds its request's result while rsp_ready is low;
//   a new request is still accepted and worked on, and waits for the slot
//   before it commits, so nothing is lost or overwritten
`default_nettype none

module round_robin_pending_bitmap import rrpb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: idle, chunk run for scans and set all, finish and commit
   rrpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // flag store, pointer, count, config and response register
   rrpb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

`default_nettype wire
